### hdl/oritmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oritmr_pkg;

   localparam int AMOUNT_WIDTH    = 32;
   localparam int PERIOD_WIDTH    = 32;
   localparam int COUNT_WIDTH     = 32;
   localparam int REMAIN_WIDTH    = 33;
   localparam int OPCODE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_TICK     = 3'd0,
      OP_RESET    = 3'd1,
      OP_PAUSE    = 3'd2,
      OP_UNPAUSE  = 3'd3,
      OP_SET      = 3'd4,
      OP_FINISH   = 3'd5,
      OP_ALMOST   = 3'd6,
      OP_NOP      = 3'd7
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PERIOD    = 1'b0,
      CSR_REPEATING = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

### hdl/oritmr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module oritmr_div #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [TIME_WIDTH-1:0]                 dividend,
   input  wire logic [oritmr_pkg::PERIOD_WIDTH-1:0]   divisor,
   output logic                                       done,
   output logic [oritmr_pkg::COUNT_WIDTH-1:0]         quotient,
   output logic [TIME_WIDTH-1:0]                      remainder
);

   localparam int CW = $clog2(TIME_WIDTH);
   localparam int MW = (TIME_WIDTH > oritmr_pkg::PERIOD_WIDTH) ?
                       TIME_WIDTH : oritmr_pkg::PERIOD_WIDTH;
   localparam int PW = oritmr_pkg::PERIOD_WIDTH;

   logic [TIME_WIDTH-1:0] dvd_ff, dvd_in;
   logic [PW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [PW:0]           trial;
   logic [PW:0]           diff;
   logic                  ge;
   logic [MW-1:0]         q_ext;
   logic [MW-1:0]         r_ext;

   // One quotient bit per cycle: shift the next dividend bit into the
   // partial remainder and subtract the divisor when it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[TIME_WIDTH-1]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[PW-1:0] : trial[PW-1:0];
         dvd_in = {dvd_ff[TIME_WIDTH-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(TIME_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      q_ext     = MW'(dvd_ff);
      r_ext     = MW'(rem_ff);
      quotient  = (q_ext > MW'(oritmr_pkg::COUNT_MAX)) ?
                  oritmr_pkg::COUNT_MAX : q_ext[oritmr_pkg::COUNT_WIDTH-1:0];
      remainder = r_ext[TIME_WIDTH-1:0];
   end

   assign done = done_ff;

endmodule

`default_nettype wire

### hdl/once_or_repeating_interval_timer_top.sv
// Interval timer in one-shot or repeating mode, driven by one command per
// transfer (tick, reset, pause, unpause, set elapsed, finish, almost finish,
// no-op) and answering each with one result transfer that shows the state
// after the command. A command is taken once the previous one has passed
// through the emit state, except that a tick, finish or almost finish that
// completes a repeating timer with a nonzero period first runs the bit-serial
// divider for the quotient and remainder, one bit per cycle. A finished
// result waits in the output register, so the next command is taken while it
// is still stalled; only a second result waits for the first.
// The period and mode registers may be written only while no command is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module once_or_repeating_interval_timer_top #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [oritmr_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  wire logic [oritmr_pkg::AMOUNT_WIDTH-1:0]     req_amount,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [oritmr_pkg::AMOUNT_WIDTH-1:0]          rsp_elapsed_now,
   output logic signed [oritmr_pkg::REMAIN_WIDTH-1:0]   rsp_remaining_now,
   output logic                                         rsp_done_res,
   output logic [oritmr_pkg::COUNT_WIDTH-1:0]           rsp_completions,
   output logic                                         rsp_halted,

   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [oritmr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [oritmr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int PW = oritmr_pkg::PERIOD_WIDTH;
   localparam int MW = (TIME_WIDTH > PW) ? TIME_WIDTH : PW;
   localparam int SW = MW + 1;
   localparam int CNT = oritmr_pkg::COUNT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;

   logic [PW-1:0]         period_ff, period_in;
   logic                  repeating_ff, repeating_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  finished_ff, finished_in;
   logic [CNT-1:0]        count_ff, count_in;
   logic                  paused_ff, paused_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [oritmr_pkg::AMOUNT_WIDTH-1:0]  rsp_elapsed_ff, rsp_elapsed_in;
   logic [oritmr_pkg::REMAIN_WIDTH-1:0]  rsp_remain_ff, rsp_remain_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic [CNT-1:0]        rsp_count_ff, rsp_count_in;
   logic                  rsp_halted_ff, rsp_halted_in;

   logic                  accept;
   logic                  slot_free;
   oritmr_pkg::opcode_type op;
   logic [SW-1:0]         target_src;
   logic [TIME_WIDTH-1:0] target;
   logic [MW-1:0]         target_ext;
   logic [MW-1:0]         period_ext;
   logic                  reaches;
   logic [MW-1:0]         elapsed_ext;
   logic [SW-1:0]         remain_full;

   logic                  div_start;
   logic                  div_done;
   logic [CNT-1:0]        div_quotient;
   logic [TIME_WIDTH-1:0] div_remainder;

   assign accept    = req_valid && state_ff == ST_IDLE;
   assign req_stall = state_ff != ST_IDLE;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign op        = oritmr_pkg::opcode_type'(req_opcode);

   always_comb begin
      unique case (op)
         oritmr_pkg::OP_TICK:   target_src = SW'(elapsed_ff) + SW'(req_amount);
         oritmr_pkg::OP_SET:    target_src = SW'(req_amount);
         oritmr_pkg::OP_FINISH: target_src = SW'(period_ff);
         oritmr_pkg::OP_ALMOST: target_src = (period_ff == '0) ? '0 :
                                             SW'(period_ff) - SW'(1);
         default:               target_src = '0;
      endcase
      target     = (|target_src[SW-1:TIME_WIDTH]) ? '1 : target_src[TIME_WIDTH-1:0];
      target_ext = MW'(target);
      period_ext = MW'(period_ff);
      reaches    = target_ext >= period_ext;
   end

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      finished_in  = finished_ff;
      count_in     = count_ff;
      paused_in    = paused_ff;
      div_start    = 1'b0;
      period_in    = period_ff;
      repeating_in = repeating_ff;

      if (csr_valid) begin
         unique case (oritmr_pkg::csr_index_type'(csr_index))
            oritmr_pkg::CSR_PERIOD:    period_in    = csr_wdata[PW-1:0];
            oritmr_pkg::CSR_REPEATING: repeating_in = csr_wdata[0];
            default:                   period_in    = period_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EMIT;
               unique case (op)
                  oritmr_pkg::OP_TICK, oritmr_pkg::OP_FINISH,
                  oritmr_pkg::OP_ALMOST: begin
                     if (paused_ff) begin
                        count_in = '0;
                        if (repeating_ff) begin
                           finished_in = 1'b0;
                        end
                     end else if (!repeating_ff && finished_ff) begin
                        count_in = '0;
                     end else begin
                        elapsed_in  = target;
                        finished_in = reaches;
                        if (!reaches) begin
                           count_in = '0;
                        end else if (!repeating_ff) begin
                           count_in   = CNT'(1);
                           elapsed_in = period_ext[TIME_WIDTH-1:0];
                        end else if (period_ff == '0) begin
                           count_in   = oritmr_pkg::COUNT_MAX;
                           elapsed_in = '0;
                        end else begin
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end
                     end
                  end
                  oritmr_pkg::OP_RESET: begin
                     elapsed_in  = '0;
                     finished_in = 1'b0;
                     count_in    = '0;
                  end
                  oritmr_pkg::OP_PAUSE:   paused_in  = 1'b1;
                  oritmr_pkg::OP_UNPAUSE: paused_in  = 1'b0;
                  oritmr_pkg::OP_SET:     elapsed_in = target;
                  default:                paused_in  = paused_ff;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               elapsed_in = div_remainder;
               count_in   = div_quotient;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      elapsed_ext    = MW'(elapsed_ff);
      remain_full    = SW'(period_ff) - SW'(elapsed_ff);
      rsp_valid_in   = rsp_valid_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_remain_in  = rsp_remain_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_halted_in  = rsp_halted_ff;
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_elapsed_in = elapsed_ext[oritmr_pkg::AMOUNT_WIDTH-1:0];
         rsp_remain_in  = remain_full[oritmr_pkg::REMAIN_WIDTH-1:0];
         rsp_done_in    = finished_ff;
         rsp_count_in   = count_ff;
         rsp_halted_in  = paused_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= '0;
         repeating_ff <= 1'b0;
         elapsed_ff   <= '0;
         finished_ff  <= 1'b0;
         count_ff     <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         repeating_ff <= repeating_in;
         elapsed_ff   <= elapsed_in;
         finished_ff  <= finished_in;
         count_ff     <= count_in;
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_remain_ff  <= rsp_remain_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_halted_ff  <= rsp_halted_in;
   end

   oritmr_div #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (target),
      .divisor   (period_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elapsed_now   = rsp_elapsed_ff;
   assign rsp_remaining_now = $signed(rsp_remain_ff);
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_completions   = rsp_count_ff;
   assign rsp_halted        = rsp_halted_ff;

endmodule

`default_nettype wire

### dv/timer_result_checker.sv
`timescale 1ns / 1ps

module timer_result_checker
   import oritmr_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [OPCODE_WIDTH-1:0]       req_opcode,
   input  wire logic [AMOUNT_WIDTH-1:0]       req_amount,

   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [AMOUNT_WIDTH-1:0]       rsp_elapsed_now,
   input  wire logic signed [REMAIN_WIDTH-1:0] rsp_remaining_now,
   input  wire logic                          rsp_done_res,
   input  wire logic [COUNT_WIDTH-1:0]        rsp_completions,
   input  wire logic                          rsp_halted,

   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_wdata,

   output int                                 fail_count,
   output int                                 pending
);

   typedef struct packed {
      logic [AMOUNT_WIDTH-1:0] elapsed;
      logic [REMAIN_WIDTH-1:0] remaining;
      logic                    done;
      logic [COUNT_WIDTH-1:0]  completions;
      logic                    halted;
   } timer_view_type;

   logic [PERIOD_WIDTH-1:0] period_cfg;
   logic                    repeat_cfg;
   logic [AMOUNT_WIDTH-1:0] elapsed_q;
   logic                    done_q;
   logic [COUNT_WIDTH-1:0]  count_q;
   logic                    paused_q;

   timer_view_type expected_views[$];
   int errors_seen = 0;

   assign fail_count = errors_seen;

   // Moves a running timer to the given elapsed value, saturated to the time width.
   function automatic void run_to(logic [AMOUNT_WIDTH:0] target);
      logic [AMOUNT_WIDTH-1:0] t;
      t = target[AMOUNT_WIDTH] ? '1 : target[AMOUNT_WIDTH-1:0];
      if (paused_q) begin
         count_q = '0;
         if (repeat_cfg) done_q = 1'b0;
         return;
      end
      if (!repeat_cfg && done_q) begin
         count_q = '0;
         return;
      end
      elapsed_q = t;
      done_q = (t >= period_cfg);
      if (!done_q) begin
         count_q = '0;
      end else if (repeat_cfg) begin
         if (period_cfg == '0) begin
            count_q = COUNT_MAX;
            elapsed_q = '0;
         end else begin
            count_q = t / period_cfg;
            elapsed_q = t % period_cfg;
         end
      end else begin
         count_q = 1;
         elapsed_q = period_cfg;
      end
   endfunction

   function automatic timer_view_type apply_command(opcode_type op,
                                                    logic [AMOUNT_WIDTH-1:0] amount);
      timer_view_type v;
      case (op)
         OP_TICK: run_to({1'b0, elapsed_q} + {1'b0, amount});
         OP_RESET: begin
            elapsed_q = '0;
            done_q = 1'b0;
            count_q = '0;
         end
         OP_PAUSE: paused_q = 1'b1;
         OP_UNPAUSE: paused_q = 1'b0;
         OP_SET: elapsed_q = amount;
         OP_FINISH: run_to({1'b0, period_cfg});
         OP_ALMOST: run_to(period_cfg == '0 ? '0 : {1'b0, period_cfg - 1'b1});
         default: ;
      endcase
      v.elapsed = elapsed_q;
      v.remaining = {1'b0, period_cfg} - {1'b0, elapsed_q};
      v.done = done_q;
      v.completions = count_q;
      v.halted = paused_q;
      return v;
   endfunction

   function automatic bit field_ok(string name, logic [REMAIN_WIDTH-1:0] want,
                                   logic [REMAIN_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      timer_view_type want;
      bit good;
      if (reset) begin
         period_cfg = '0;
         repeat_cfg = 1'b0;
         elapsed_q = '0;
         done_q = 1'b0;
         count_q = '0;
         paused_q = 1'b0;
         expected_views.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               $display("%0t: result transfer with no command outstanding", $time);
               errors_seen++;
            end else begin
               want = expected_views.pop_front();
               good = field_ok("elapsed_now", want.elapsed, rsp_elapsed_now)
                    & field_ok("remaining_now", want.remaining, rsp_remaining_now)
                    & field_ok("done_res", want.done, rsp_done_res)
                    & field_ok("completions", want.completions, rsp_completions)
                    & field_ok("halted", want.halted, rsp_halted);
               if (!good) errors_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PERIOD: period_cfg = csr_wdata;
               CSR_REPEATING: repeat_cfg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_views.push_back(apply_command(opcode_type'(req_opcode), req_amount));
      end
      pending <= expected_views.size();
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import oritmr_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int GAP_PERCENT = 26;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OPCODE_WIDTH-1:0]    req_opcode = OP_NOP;
   logic [AMOUNT_WIDTH-1:0]    req_amount = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [AMOUNT_WIDTH-1:0]    rsp_elapsed_now;
   logic signed [REMAIN_WIDTH-1:0] rsp_remaining_now;
   logic                       rsp_done_res;
   logic [COUNT_WIDTH-1:0]     rsp_completions;
   logic                       rsp_halted;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_PERIOD;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   bit gaps_on = 1'b1;
   bit hold_off_go = 1'b0;
   logic [PERIOD_WIDTH-1:0] period_now = '0;
   int quiet_cycles = 0;
   int fail_count;
   int pending;

   once_or_repeating_interval_timer_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_amount(req_amount),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_elapsed_now(rsp_elapsed_now),
      .rsp_remaining_now(rsp_remaining_now),
      .rsp_done_res(rsp_done_res),
      .rsp_completions(rsp_completions),
      .rsp_halted(rsp_halted),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   timer_result_checker results (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_amount(req_amount),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_elapsed_now(rsp_elapsed_now),
      .rsp_remaining_now(rsp_remaining_now),
      .rsp_done_res(rsp_done_res),
      .rsp_completions(rsp_completions),
      .rsp_halted(rsp_halted),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("once_or_repeating_interval_timer_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_command(opcode_type op, logic [AMOUNT_WIDTH-1:0] amount);
      if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (gaps_on && $urandom_range(99) < GAP_PERCENT);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_amount <= amount;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The mode register only looks at bit 0, so the upper bits carry noise.
   task automatic configure(logic [PERIOD_WIDTH-1:0] period, logic rep);
      logic [CSR_DATA_WIDTH-1:0] mode_word;
      mode_word = $urandom;
      mode_word[0] = rep;
      drain_results();
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_REPEATING, mode_word);
      period_now = period;
   endtask

   function automatic opcode_type pick_opcode();
      int r;
      r = $urandom_range(99);
      if (r < 40) return OP_TICK;
      if (r < 48) return OP_RESET;
      if (r < 56) return OP_PAUSE;
      if (r < 66) return OP_UNPAUSE;
      if (r < 76) return OP_SET;
      if (r < 86) return OP_FINISH;
      if (r < 94) return OP_ALMOST;
      return OP_NOP;
   endfunction

   function automatic logic [AMOUNT_WIDTH-1:0] pick_amount();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         default: begin
            if (period_now > 32'h3FFF_FFFF) return $urandom;
            return $urandom_range(period_now * 4 + 3);
         end
      endcase
   endfunction

   initial begin
      logic [PERIOD_WIDTH-1:0] phase_period;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(32'd10, 1'b0);
      send_command(OP_TICK, 32'd3);
      send_command(OP_TICK, 32'd0);
      send_command(OP_TICK, 32'd7);
      send_command(OP_TICK, 32'd5);
      send_command(OP_RESET, '1);
      send_command(OP_ALMOST, '1);
      send_command(OP_SET, '1);
      send_command(OP_FINISH, 32'd0);
      send_command(OP_PAUSE, 32'd0);
      send_command(OP_TICK, 32'd4);
      send_command(OP_UNPAUSE, 32'd0);
      send_command(OP_NOP, '1);
      send_command(OP_RESET, 32'd0);
      send_command(OP_SET, 32'hFFFF_FFF0);
      send_command(OP_TICK, '1);

      configure(32'd7, 1'b1);
      send_command(OP_TICK, 32'd30);
      send_command(OP_PAUSE, 32'd0);
      send_command(OP_TICK, 32'd1);
      send_command(OP_UNPAUSE, 32'd0);
      send_command(OP_FINISH, 32'd0);
      send_command(OP_ALMOST, 32'd0);
      send_command(OP_SET, '1);
      send_command(OP_TICK, '1);

      configure(32'd0, 1'b1);
      send_command(OP_TICK, 32'd0);
      configure(32'd0, 1'b0);
      send_command(OP_ALMOST, 32'd0);
      configure(32'd1, 1'b1);
      send_command(OP_TICK, '1);
      configure('1, 1'b0);
      send_command(OP_TICK, '1);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 8)
            0: phase_period = '0;
            1: phase_period = 32'd1;
            2: phase_period = '1;
            3: phase_period = $urandom;
            4: phase_period = 32'hFFFF_FFFE;
            default: phase_period = $urandom_range(40, 2);
         endcase
         configure(phase_period, p % 3 == 0);
         gaps_on = !(p == 2 || p == 3);
         if (p == 5) hold_off_go = 1'b1;
         repeat (PHASE_ITEMS) send_command(pick_opcode(), pick_amount());
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("once_or_repeating_interval_timer_top regression: pass");
      end else begin
         $display("once_or_repeating_interval_timer_top regression: fail");
      end
      $finish;
   end

endmodule

### files.f
hdl/oritmr_pkg.sv
hdl/oritmr_div.sv
hdl/once_or_repeating_interval_timer_top.sv
dv/timer_result_checker.sv
dv/tb_top.sv
